@@ rtl/core/mmd_pkg.sv @@
// Shared types, character codes and helper functions for the meter message deframer.
// Depends on nothing; imported by meter_message_deframer and the testbench.
package mmd_pkg;

  // Message framing
  localparam int MsgLen = 16;
  localparam int PosW   = $clog2(MsgLen);

  // Byte positions inside a message
  localparam int StampFirst = 1;
  localparam int StampLast  = 4;
  localparam int StampSep   = 5;
  localparam int SignPos    = 8;
  localparam int ValFirst   = 9;
  localparam int ValLast    = 14;

  // Field widths
  localparam int ByteW    = 8;
  localparam int StampW   = 16;
  localparam int ReadW    = 38;
  localparam int MagW     = ReadW - 1;
  localparam int ValAccW  = 20;   // six decimal digits
  localparam int ScaleW   = 17;   // up to 10^5
  localparam int FracW    = 3;
  localparam int StatusW  = 2;
  localparam int TuserW   = 3;
  localparam int TdataW   = 168;  // 163 bits of fields, padded to bytes

  // Configuration port
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 16;
  localparam logic [CfgAddrW-1:0] CFG_LAG_LIMIT     = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_RECORD_ENABLE = 2'd1;
  localparam logic [CfgDataW-1:0] LAG_LIMIT_RESET   = 16'd1000;

  // Status codes
  localparam logic [StatusW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatusW-1:0] STATUS_BAD_STAMP = 2'd1;
  localparam logic [StatusW-1:0] STATUS_BAD_VALUE = 2'd2;

  // Character codes
  localparam logic [ByteW-1:0] CH_X     = 8'h58;
  localparam logic [ByteW-1:0] CH_Y     = 8'h59;
  localparam logic [ByteW-1:0] CH_LF    = 8'h0A;
  localparam logic [ByteW-1:0] CH_MINUS = 8'h2D;
  localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
  localparam logic [ByteW-1:0] CH_DOT   = 8'h2E;
  localparam logic [ByteW-1:0] CH_0     = 8'h30;
  localparam logic [ByteW-1:0] CH_9     = 8'h39;
  localparam logic [ByteW-1:0] CH_LA    = 8'h61;
  localparam logic [ByteW-1:0] CH_LF_HEX = 8'h66;  // 'f'
  localparam logic [ByteW-1:0] CH_UA    = 8'h41;
  localparam logic [ByteW-1:0] CH_UF    = 8'h46;

  // Framing state
  typedef enum logic [2:0] {
    HUNT      = 3'b001,
    COLLECT_X = 3'b010,
    COLLECT_Y = 3'b100
  } hunt_t;

  // One result word before packing
  typedef struct packed {
    logic [StatusW-1:0]      status;
    logic                    channel;
    logic [StampW-1:0]       stamp;
    logic signed [ReadW-1:0] reading;
    logic [StampW-1:0]       period;
    logic [StampW-1:0]       lag;
    logic                    point_valid;
    logic signed [ReadW-1:0] point_x;
    logic signed [ReadW-1:0] point_y;
  } result_t;

  // Hex digit decode: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [ByteW-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_0 && c <= CH_9) begin
      r = {1'b1, 4'(c - CH_0)};
    end else if (c >= CH_LA && c <= CH_LF_HEX) begin
      r = {1'b1, 4'(c - CH_LA + 8'd10)};
    end else if (c >= CH_UA && c <= CH_UF) begin
      r = {1'b1, 4'(c - CH_UA + 8'd10)};
    end
    return r;
  endfunction

  // Scale factor 10^(5 - frac)
  function automatic logic [ScaleW-1:0] frac_scale(input logic [FracW-1:0] frac);
    logic [ScaleW-1:0] s;
    case (frac)
      3'd0:    s = 17'd100000;
      3'd1:    s = 17'd10000;
      3'd2:    s = 17'd1000;
      3'd3:    s = 17'd100;
      3'd4:    s = 17'd10;
      default: s = 17'd1;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/core/meter_message_deframer.sv @@
// Meter message deframer: frames and parses 16-byte meter messages from a byte stream.
// Depends on mmd_pkg for types, character codes and decode functions.
//
//  channel   dir  tdata / data                      tuser               last
//  s_*       in   [7:0] rx_byte                      -                   -
//  m_*       out  stamp, reading, period, lag, ...   [1:0] status, [2] ch -
//  cfg_*     in   cfg_wdata (index 0 lag_limit,      -                   -
//                 index 1 record_enable)
//
// One byte is taken per cycle while s_tready is high. Timestamp and value are
// accumulated as their bytes arrive; the final byte of a message does one 20x17
// scale multiply and the stamp compares, and the result word is registered at the
// same edge. A two-entry output (register plus skid) lets input flow on while a
// result waits; s_tready drops only while both entries are full. Reset is
// synchronous and clears framing, last stamps, last readings and configuration.
module meter_message_deframer (
  input  logic                          clk,
  input  logic                          rst,
  // input bytes
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
  // results
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mmd_pkg::TdataW-1:0]    m_tdata,   // stamp[15:0], reading[53:16],
                                                   // period[69:54], lag[85:70],
                                                   // point_valid[86], point_x[124:87],
                                                   // point_y[162:125], zero pad
  output logic [mmd_pkg::TuserW-1:0]    m_tuser,   // status[1:0], channel[2]
  // configuration
  input  logic                          cfg_wen,
  input  logic [mmd_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [mmd_pkg::CfgDataW-1:0]  cfg_wdata
);
  import mmd_pkg::*;

  localparam logic [PosW-1:0] LastPos = PosW'(MsgLen - 1);

  // Configuration registers
  logic [CfgDataW-1:0] lag_limit;
  logic                record_enable;

  // Framing and parse state
  hunt_t               hunt, hunt_next;
  logic [PosW-1:0]     pos, pos_next;
  logic [StampW-1:0]   stamp_acc, stamp_acc_next;
  logic                stamp_bad, stamp_bad_next;
  logic                neg, neg_next;
  logic [ValAccW-1:0]  val_acc, val_acc_next;
  logic [FracW-1:0]    val_frac, val_frac_next;
  logic                val_point, val_point_next;
  logic                val_digit, val_digit_next;
  logic                val_bad, val_bad_next;

  // Per-meter history
  logic [StampW-1:0]       last_stamp_x, last_stamp_y;
  logic signed [ReadW-1:0] last_reading_x, last_reading_y;

  // Output register and skid
  result_t out_word, skid_word, res;
  logic    skid_valid;
  logic    res_valid;

  logic              accept;
  logic [ByteW-1:0]  c;
  logic [4:0]        hex;
  logic              is_digit;
  logic              chan;
  logic [MagW-1:0]   mag;
  logic signed [ReadW-1:0] reading_ok;
  logic [StampW-1:0] period_ok, lag_ok;
  logic              ok;
  logic              out_free;

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign c        = s_tdata;
  assign hex      = hex_digit(c);
  assign is_digit = (c >= CH_0) && (c <= CH_9);
  assign out_free = !m_tvalid || m_tready;

  // Framing and incremental field parsing
  always_comb begin
    hunt_next      = hunt;
    pos_next       = pos;
    stamp_acc_next = stamp_acc;
    stamp_bad_next = stamp_bad;
    neg_next       = neg;
    val_acc_next   = val_acc;
    val_frac_next  = val_frac;
    val_point_next = val_point;
    val_digit_next = val_digit;
    val_bad_next   = val_bad;
    res_valid      = 1'b0;
    chan           = (hunt == COLLECT_Y);
    if (accept) begin
      unique case (hunt)
        HUNT: begin
          if (c == CH_X || c == CH_Y) begin
            hunt_next      = (c == CH_X) ? COLLECT_X : COLLECT_Y;
            pos_next       = PosW'(1);
            stamp_acc_next = '0;
            stamp_bad_next = 1'b0;
            neg_next       = 1'b0;
            val_acc_next   = '0;
            val_frac_next  = '0;
            val_point_next = 1'b0;
            val_digit_next = 1'b0;
            val_bad_next   = 1'b0;
          end
        end
        COLLECT_X, COLLECT_Y: begin
          // a letter inside a message retargets the channel
          if (c == CH_X) begin
            hunt_next = COLLECT_X;
            chan      = 1'b0;
          end else if (c == CH_Y) begin
            hunt_next = COLLECT_Y;
            chan      = 1'b1;
          end
          // timestamp digits and separator
          if (pos >= PosW'(StampFirst) && pos <= PosW'(StampLast)) begin
            if (hex[4]) begin
              stamp_acc_next = {stamp_acc[StampW-5:0], hex[3:0]};
            end else begin
              stamp_bad_next = 1'b1;
            end
          end
          if (pos == PosW'(StampSep) && c != CH_SPACE) begin
            stamp_bad_next = 1'b1;
          end
          if (pos == PosW'(SignPos)) begin
            neg_next = (c == CH_MINUS);
          end
          // value characters
          if (pos >= PosW'(ValFirst) && pos <= PosW'(ValLast)) begin
            if (is_digit) begin
              val_acc_next   = (val_acc << 3) + (val_acc << 1) + ValAccW'(c - CH_0);
              val_digit_next = 1'b1;
              if (val_point) begin
                val_frac_next = val_frac + FracW'(1);
              end
            end else if (c == CH_DOT && !val_point) begin
              val_point_next = 1'b1;
            end else begin
              val_bad_next = 1'b1;
            end
          end
          // end of message or early line feed
          if (pos == LastPos) begin
            hunt_next = HUNT;
            pos_next  = '0;
            res_valid = 1'b1;
          end else begin
            pos_next = pos + PosW'(1);
            if (c == CH_LF) begin
              hunt_next = HUNT;
              pos_next  = '0;
            end
          end
        end
        default: begin
          hunt_next = HUNT;
          pos_next  = '0;
        end
      endcase
    end
  end

  // Result word for a completed message
  assign mag        = MagW'(val_acc) * MagW'(frac_scale(val_frac));
  assign reading_ok = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign period_ok  = chan ? (stamp_acc - last_stamp_y) : (stamp_acc - last_stamp_x);
  assign lag_ok     = chan ? (stamp_acc - last_stamp_x) : (stamp_acc - last_stamp_y);
  assign ok         = !stamp_bad && !val_bad && val_digit;

  always_comb begin
    res             = '0;
    res.channel     = chan;
    res.point_x     = last_reading_x;
    res.point_y     = last_reading_y;
    if (stamp_bad) begin
      res.status = STATUS_BAD_STAMP;
    end else if (!ok) begin
      res.status = STATUS_BAD_VALUE;
      res.stamp  = stamp_acc;
    end else begin
      res.status      = STATUS_OK;
      res.stamp       = stamp_acc;
      res.reading     = reading_ok;
      res.period      = period_ok;
      res.lag         = lag_ok;
      res.point_valid = (lag_ok < lag_limit) && record_enable;
      if (chan) begin
        res.point_y = reading_ok;
      end else begin
        res.point_x = reading_ok;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      lag_limit     <= LAG_LIMIT_RESET;
      record_enable <= 1'b1;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        CFG_LAG_LIMIT:     lag_limit     <= cfg_wdata;
        CFG_RECORD_ENABLE: record_enable <= cfg_wdata[0];
        default:           ;
      endcase
    end
  end

  // Framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      hunt <= HUNT;
      pos  <= '0;
    end else begin
      hunt <= hunt_next;
      pos  <= pos_next;
    end
  end

  // Parse accumulators
  always_ff @(posedge clk) begin
    stamp_acc <= stamp_acc_next;
    stamp_bad <= stamp_bad_next;
    neg       <= neg_next;
    val_acc   <= val_acc_next;
    val_frac  <= val_frac_next;
    val_point <= val_point_next;
    val_digit <= val_digit_next;
    val_bad   <= val_bad_next;
  end

  // Per-meter history, updated by good messages only
  always_ff @(posedge clk) begin
    if (rst) begin
      last_stamp_x   <= '0;
      last_stamp_y   <= '0;
      last_reading_x <= '0;
      last_reading_y <= '0;
    end else if (res_valid && ok) begin
      if (chan) begin
        last_stamp_y   <= stamp_acc;
        last_reading_y <= reading_ok;
      end else begin
        last_stamp_x   <= stamp_acc;
        last_reading_x <= reading_ok;
      end
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= res_valid;
      end else begin
        m_tvalid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_word  <= skid_word;
        skid_word <= res;
      end else begin
        out_word <= res;
      end
    end else if (res_valid) begin
      skid_word <= res;
    end
  end

  // Pack the word
  assign m_tuser = {out_word.channel, out_word.status};
  assign m_tdata = {5'd0, out_word.point_y, out_word.point_x, out_word.point_valid,
                    out_word.lag, out_word.period, out_word.reading, out_word.stamp};

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for meter_message_deframer: framed meter messages in, result words out.
// Depends on mmd_pkg and the deframer RTL; results are predicted in-bench and checked in order.
module testbench;
  import mmd_pkg::*;

  // Bytes that only the stimulus uses
  localparam logic [ByteW-1:0]    CH_PLUS = 8'h2B;
  localparam logic [ByteW-1:0]    CH_E    = 8'h65;
  // Register indexes the block must ignore
  localparam logic [CfgAddrW-1:0] CFG_UNUSED_LO = 2'd2;
  localparam logic [CfgAddrW-1:0] CFG_UNUSED_HI = 2'd3;
  localparam int RANDOM_BYTES = 1460;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [TdataW-1:0]    m_tdata;   // stamp, reading, period, lag, point_valid, point_x, point_y
  logic [TuserW-1:0]    m_tuser;   // status[1:0], channel[2]
  logic                 cfg_wen = 1'b0;
  logic [CfgAddrW-1:0]  cfg_addr = '0;
  logic [CfgDataW-1:0]  cfg_wdata = '0;

  meter_message_deframer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Mirror of the deframer state and registers
  hunt_t                  frame_state;
  int unsigned            frame_count;
  logic [ByteW-1:0]       msg_store [MsgLen];
  logic [StampW-1:0]      prev_stamp_x, prev_stamp_y;
  logic signed [ReadW-1:0] prev_read_x, prev_read_y;
  logic [StampW-1:0]      lag_limit_reg;
  logic                   record_reg;

  result_t                pending_results [$];
  logic [ByteW-1:0]       frame_buf [MsgLen];
  logic [StampW-1:0]      stamp_base = '0;
  int                     taken_bytes = 0;
  int                     errors = 0;
  bit                     idle_on = 1'b0;
  int                     ready_hold = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case a handshake hangs
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic bit nibble_of(input logic [7:0] c, output logic [3:0] n);
    n = '0;
    if (c >= CH_0 && c <= CH_9) n = 4'(c - CH_0);
    else if (c >= CH_LA && c <= CH_LF_HEX) n = 4'(c - CH_LA + 8'd10);
    else if (c >= CH_UA && c <= CH_UF) n = 4'(c - CH_UA + 8'd10);
    else return 1'b0;
    return 1'b1;
  endfunction

  // Four hex digits followed by a space
  function automatic bit decode_stamp(output logic [StampW-1:0] st);
    logic [3:0] n;
    int k;
    st = '0;
    for (k = StampFirst; k <= StampLast; k++) begin
      if (!nibble_of(msg_store[k], n)) return 1'b0;
      st = {st[11:0], n};
    end
    return msg_store[StampSep] == CH_SPACE;
  endfunction

  // Six chars of digits with at most one point, scaled to 1e-5 units
  function automatic bit decode_value(output logic signed [63:0] v);
    logic signed [63:0] acc;
    logic [7:0] c;
    int frac, digits, k;
    bit dot;
    acc = 0; frac = 0; digits = 0; dot = 1'b0; v = 0;
    for (k = ValFirst; k <= ValLast; k++) begin
      c = msg_store[k];
      if (c >= CH_0 && c <= CH_9) begin
        acc = acc * 10 + 64'(c - CH_0);
        digits++;
        if (dot) frac++;
      end else if (c == CH_DOT && !dot) begin
        dot = 1'b1;
      end else begin
        return 1'b0;
      end
    end
    if (digits == 0) return 1'b0;
    for (k = frac; k < 5; k++) acc = acc * 10;
    if (msg_store[SignPos] == CH_MINUS) acc = -acc;
    v = acc;
    return 1'b1;
  endfunction

  // Advance the mirror by one accepted byte, queue a result when a message completes
  task automatic deframe_byte(input logic [7:0] c);
    result_t r;
    logic [StampW-1:0] st;
    logic signed [63:0] val;
    bit letter;
    letter = (c == CH_X) || (c == CH_Y);
    if (frame_state == HUNT) begin
      if (letter) begin
        frame_state = (c == CH_X) ? COLLECT_X : COLLECT_Y;
        msg_store[0] = c;
        frame_count = 1;
        taken_bytes++;
      end
      return;
    end
    taken_bytes++;
    // a letter mid-message is data but also retargets the channel
    if (letter) frame_state = (c == CH_X) ? COLLECT_X : COLLECT_Y;
    msg_store[frame_count] = c;
    frame_count++;
    if (frame_count < MsgLen) begin
      if (c == CH_LF) begin
        frame_state = HUNT;
        frame_count = 0;
      end
      return;
    end
    r = '0;
    r.channel = (frame_state == COLLECT_Y);
    frame_state = HUNT;
    frame_count = 0;
    if (!decode_stamp(st)) begin
      r.status = STATUS_BAD_STAMP;
    end else if (!decode_value(val)) begin
      r.status = STATUS_BAD_VALUE;
      r.stamp = st;
    end else begin
      r.status = STATUS_OK;
      r.stamp = st;
      r.reading = val[ReadW-1:0];
      if (!r.channel) begin
        r.period = st - prev_stamp_x;
        r.lag = st - prev_stamp_y;
        prev_stamp_x = st;
        prev_read_x = val[ReadW-1:0];
      end else begin
        r.period = st - prev_stamp_y;
        r.lag = st - prev_stamp_x;
        prev_stamp_y = st;
        prev_read_y = val[ReadW-1:0];
      end
      r.point_valid = (r.lag < lag_limit_reg) && record_reg;
    end
    r.point_x = prev_read_x;
    r.point_y = prev_read_y;
    pending_results = {pending_results, r};
  endtask

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input logic signed [63:0] e,
                             input logic signed [63:0] a);
    if (a !== e) begin
      $error("%s mismatch: expected %0d, actual %0d", name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.status      = m_tuser[1:0];
      got.channel     = m_tuser[2];
      got.stamp       = m_tdata[15:0];
      got.reading     = m_tdata[53:16];
      got.period      = m_tdata[69:54];
      got.lag         = m_tdata[85:70];
      got.point_valid = m_tdata[86];
      got.point_x     = m_tdata[124:87];
      got.point_y     = m_tdata[162:125];
      if (pending_results.size() == 0) begin
        $error("result word with no pending expectation");
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, got.status);
        check_field("channel", want.channel, got.channel);
        check_field("stamp", want.stamp, got.stamp);
        check_field("reading", want.reading, got.reading);
        check_field("period", want.period, got.period);
        check_field("lag", want.lag, got.lag);
        check_field("point_valid", want.point_valid, got.point_valid);
        check_field("point_x", want.point_x, got.point_x);
        check_field("point_y", want.point_y, got.point_y);
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 90);
    return $urandom_range(1, 3);
  endfunction

  // Result-side back-pressure
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      ready_hold <= pick_gap();
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    s_tdata <= b;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    deframe_byte(b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic send_frame(input int len);
    int i;
    for (i = 0; i < len; i++) send_byte(frame_buf[i]);
  endtask

  // Hold off input until every pending result word is out, then let the pipe settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] data);
    wait_idle();
    cfg_addr <= idx;
    cfg_wdata <= data;
    cfg_wen <= 1'b1;
    @(posedge clk);
    if (idx == CFG_LAG_LIMIT) lag_limit_reg = data;
    else if (idx == CFG_RECORD_ENABLE) record_reg = data[0];
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- message building

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 10) return CH_0 + 8'(n);
    return (upper ? CH_UA : CH_LA) + 8'(n) - 8'd10;
  endfunction

  // Mostly a space, sometimes any byte but a line feed
  function automatic logic [7:0] filler_byte();
    logic [7:0] r;
    r = 8'($urandom);
    if (r == CH_LF || $urandom_range(0, 3) != 0) r = CH_SPACE;
    return r;
  endfunction

  function automatic logic [7:0] pick_letter();
    return $urandom_range(0, 1) ? CH_Y : CH_X;
  endfunction

  // Well-formed message with random case, filler and value text
  task automatic make_frame(input logic [7:0] letter, input logic [StampW-1:0] st,
                            input bit neg);
    int i, dot_at;
    frame_buf[0] = letter;
    for (i = 0; i < 4; i++)
      frame_buf[StampFirst+i] = hex_char(st[15-4*i -: 4], 1'($urandom_range(0, 1)));
    frame_buf[StampSep] = CH_SPACE;
    frame_buf[6] = filler_byte();
    frame_buf[7] = filler_byte();
    frame_buf[SignPos] = neg ? CH_MINUS : filler_byte();
    dot_at = $urandom_range(0, 6);  // 6: no point
    for (i = 0; i <= ValLast - ValFirst; i++)
      frame_buf[ValFirst+i] = (i == dot_at) ? CH_DOT : CH_0 + 8'($urandom_range(0, 9));
    frame_buf[MsgLen-1] = CH_LF;
  endtask

  task automatic put_text(input int pos, input string s);
    int i;
    for (i = 0; i < s.len(); i++) frame_buf[pos+i] = s[i];
  endtask

  // ---------------------------------------------------------------- tests

  // Stamp and value extremes, hex case, point placement, negative zero
  task automatic test_field_extremes();
    idle_on = 1'b0;
    make_frame(CH_X, 16'h0000, 1'b0); put_text(SignPos, "+000000"); send_frame(MsgLen);
    make_frame(CH_Y, 16'hFFFF, 1'b1); put_text(ValFirst, "999999"); send_frame(MsgLen);
    make_frame(CH_X, 16'h0000, 1'b0); put_text(StampFirst, "aBcD");
    put_text(ValFirst, ".00001"); send_frame(MsgLen);
    make_frame(CH_Y, 16'hABD0, 1'b1); put_text(ValFirst, "000000"); send_frame(MsgLen);
    make_frame(CH_X, 16'hABE0, 1'b0); put_text(ValFirst, "99999."); send_frame(MsgLen);
    make_frame(CH_Y, 16'hABF0, 1'b0); put_text(SignPos, " 12.345"); send_frame(MsgLen);
    make_frame(CH_X, 16'hFFFF, 1'b1); put_text(ValFirst, "9.9999"); send_frame(MsgLen);
  endtask

  // Bad timestamp, bad separator and bad value text
  task automatic test_format_errors();
    idle_on = 1'b1;
    make_frame(CH_X, 16'h1234, 1'b0); put_text(StampFirst, "12g4"); send_frame(MsgLen);
    make_frame(CH_Y, 16'h1235, 1'b0); put_text(StampSep, "_"); send_frame(MsgLen);
    // 'X' inside the stamp: bad stamp, channel flips to X
    make_frame(CH_Y, 16'h1236, 1'b0); put_text(2, "X"); send_frame(MsgLen);
    make_frame(CH_X, 16'h1237, 1'b0); put_text(ValFirst, "1..234"); send_frame(MsgLen);
    make_frame(CH_Y, 16'h1238, 1'b0); put_text(ValFirst, "+12345"); send_frame(MsgLen);
    make_frame(CH_X, 16'h1239, 1'b1); put_text(ValFirst, " 12345"); send_frame(MsgLen);
    make_frame(CH_Y, 16'h123A, 1'b0); put_text(ValFirst, "1e0001"); send_frame(MsgLen);
    make_frame(CH_X, 16'h123B, 1'b0); put_text(ValFirst, "12345-"); send_frame(MsgLen);
  endtask

  // Hunt noise, early line feeds, letters mid-message, odd final bytes
  task automatic test_framing();
    idle_on = 1'b1;
    send_byte(8'h00); send_byte(8'hFF); send_byte(CH_LF); send_byte(8'h80); send_byte(8'h7F);
    make_frame(CH_X, 16'h0200, 1'b0); frame_buf[7] = CH_LF; send_frame(8);
    send_byte(CH_Y); send_byte(CH_LF);
    make_frame(CH_Y, 16'h0201, 1'b0); frame_buf[MsgLen-2] = CH_LF; send_frame(MsgLen - 1);
    make_frame(CH_X, 16'h0202, 1'b0); frame_buf[7] = CH_Y; send_frame(MsgLen);
    make_frame(CH_Y, 16'h0203, 1'b1); frame_buf[MsgLen-1] = CH_X; send_frame(MsgLen);
    make_frame(CH_X, 16'h0204, 1'b0); frame_buf[MsgLen-1] = 8'h41; send_frame(MsgLen);
  endtask

  // Limit extremes, recording off, masked enable bit, ignored indexes
  task automatic test_register_sweep();
    idle_on = 1'b1;
    write_reg(CFG_LAG_LIMIT, 16'h0000);
    make_frame(CH_X, 16'h2000, 1'b0); send_frame(MsgLen);
    make_frame(CH_Y, 16'h2000, 1'b0); send_frame(MsgLen);
    write_reg(CFG_LAG_LIMIT, 16'hFFFF);
    make_frame(CH_Y, 16'h1FFF, 1'b0); send_frame(MsgLen);  // lag of all ones
    make_frame(CH_X, 16'h2001, 1'b1); send_frame(MsgLen);
    write_reg(CFG_RECORD_ENABLE, 16'hFFFE);
    make_frame(CH_Y, 16'h2002, 1'b0); send_frame(MsgLen);
    write_reg(CFG_UNUSED_LO, 16'($urandom));
    write_reg(CFG_UNUSED_HI, 16'($urandom));
    make_frame(CH_X, 16'h2003, 1'b0); send_frame(MsgLen);
    write_reg(CFG_RECORD_ENABLE, 16'h0001);
    write_reg(CFG_LAG_LIMIT, LAG_LIMIT_RESET);
    make_frame(CH_Y, 16'h2004, 1'b0); send_frame(MsgLen);
  endtask

  // One random message, mostly well formed, sometimes corrupted or truncated
  task automatic send_random_message();
    int pick, pos, len;
    logic [7:0] junk;
    if ($urandom_range(0, 15) == 0) stamp_base = 16'($urandom);
    else stamp_base = stamp_base + 16'($urandom_range(0, 600));
    make_frame(pick_letter(), stamp_base, 1'($urandom_range(0, 1)));
    len = MsgLen;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      frame_buf[$urandom_range(StampFirst, StampSep)] = 8'($urandom);
    end else if (pick < 16) begin
      case ($urandom_range(0, 5))
        0:       junk = CH_DOT;
        1:       junk = CH_MINUS;
        2:       junk = CH_PLUS;
        3:       junk = CH_SPACE;
        4:       junk = CH_E;
        default: junk = 8'($urandom);
      endcase
      frame_buf[$urandom_range(ValFirst, ValLast)] = junk;
    end else if (pick < 21) begin
      pos = $urandom_range(1, MsgLen - 2);
      frame_buf[pos] = CH_LF;
      len = pos + 1;
    end else if (pick < 25) begin
      frame_buf[$urandom_range(1, MsgLen - 1)] = pick_letter();
    end else if (pick < 30) begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
    end
    send_frame(len);
  endtask

  // Random traffic in phases with different settings and idling
  task automatic test_random_traffic();
    int phase, goal;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_on = 1'b0;
        end
        1: begin
          idle_on = 1'b1;
          write_reg(CFG_LAG_LIMIT, 16'($urandom));
        end
        2: begin
          idle_on = 1'b1;
          write_reg(CFG_LAG_LIMIT, $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 400)));
          write_reg(CFG_RECORD_ENABLE, 16'($urandom));
        end
        default: begin
          idle_on = 1'b1;
          write_reg(CFG_LAG_LIMIT, 16'($urandom_range(100, 2000)));
          write_reg(CFG_RECORD_ENABLE, 16'h0001);
        end
      endcase
      goal = taken_bytes + RANDOM_BYTES / 4;
      while (taken_bytes < goal) begin
        send_random_message();
        // late in phase 1, drain at random so the sender sees a fully empty block
        if (phase == 1 && taken_bytes >= goal - RANDOM_BYTES / 8 && $urandom_range(0, 7) == 0)
          wait_idle();
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    frame_state = HUNT;
    frame_count = 0;
    prev_stamp_x = '0;
    prev_stamp_y = '0;
    prev_read_x = '0;
    prev_read_y = '0;
    lag_limit_reg = LAG_LIMIT_RESET;
    record_reg = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_extremes();
    test_format_errors();
    test_framing();
    test_register_sweep();
    test_random_traffic();

    wait_idle();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d result words never arrived", pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
